[src/kwm_pkg.sv]
// Shared constants, payload types, sequencer states and address helper for the k-way merge.
package kwm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 256;

    localparam int VAL_W     = 32;
    localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int REM_W     = $clog2(RAM_DEPTH + 1);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PULL  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [2:0]              list_index;
        logic signed [VAL_W-1:0] value;
    } kwm_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic                    valid_res;
        logic                    last;
        logic                    overflow;
    } kwm_result_t;

    // One step for the compare unit: the head of list idx arrives from the RAM this cycle.
    typedef struct packed {
        logic              clr;
        logic              step;
        logic [LIST_W-1:0] idx;
        logic              nonempty;
        logic [CNT_W-1:0]  count;
    } kwm_cmp_ctl_t;

    typedef struct packed {
        logic                    found;
        logic [LIST_W-1:0]       best_idx;
        logic signed [VAL_W-1:0] best_val;
        logic [REM_W-1:0]        remaining;
    } kwm_cmp_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_ADVANCE,
        ST_FINISH
    } kwm_state_t;

    // Lists occupy consecutive slices of LIST_DEPTH words in the element RAM.
    function automatic logic [RAM_AW-1:0] kwm_addr(input logic [LIST_W-1:0] idx,
                                                   input logic [CNT_W-1:0] pos);
        logic [RAM_AW-1:0] base;
        base = RAM_AW'(idx) * RAM_AW'(LIST_DEPTH);
        return base + RAM_AW'(pos);
    endfunction

endpackage

[src/kwm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/kwm_minsel.sv]
// Shared compare unit: keeps the running minimum head and the count of remaining elements.
module kwm_minsel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kwm_pkg::kwm_cmp_ctl_t             ctl,
    input  logic signed [kwm_pkg::VAL_W-1:0]  head,
    output kwm_pkg::kwm_cmp_stat_t            stat
);
    import kwm_pkg::*;

    logic                    found_reg, found_next;
    logic [LIST_W-1:0]       best_idx_reg, best_idx_next;
    logic signed [VAL_W-1:0] best_val_reg, best_val_next;
    logic [REM_W-1:0]        remaining_reg, remaining_next;
    logic                    take;

    // Strict less-than keeps the lowest list index on ties, since lists are visited in order.
    assign take = ctl.step && ctl.nonempty && (!found_reg || (head < best_val_reg));

    always_comb
    begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        remaining_next = remaining_reg;
        if (ctl.clr)
        begin
            found_next     = 1'b0;
            remaining_next = '0;
        end
        else
        begin
            if (ctl.step && ctl.nonempty)
            begin
                remaining_next = remaining_reg + REM_W'(ctl.count);
            end
            if (take)
            begin
                found_next    = 1'b1;
                best_idx_next = ctl.idx;
                best_val_next = head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            remaining_reg <= '0;
        end
        else
        begin
            found_reg     <= found_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
    end

    assign stat.found     = found_reg;
    assign stat.best_idx  = best_idx_reg;
    assign stat.best_val  = best_val_reg;
    assign stat.remaining = remaining_reg;

endmodule

[src/k_way_merge_min_select.sv]
// Merges up to NUM_LISTS sorted lists held in one element RAM; every transfer in gives one
// result transfer out. A load passes through ST_LOAD and ST_FINISH, and a clear or an
// undefined operation through ST_FINISH alone; a pull walks the list heads one list per
// cycle through a single shared comparator in ST_SCAN, then passes ST_DRAIN, ST_PICK,
// ST_ADVANCE and ST_FINISH. The input is stalled while an item is in progress, and the
// result register lets the next item be accepted while a finished result still waits to
// be taken.
module k_way_merge_min_select (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  kwm_pkg::kwm_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output kwm_pkg::kwm_result_t result
);
    import kwm_pkg::*;

    kwm_state_t state_reg, state_next;

    logic [1:0]              op_reg;
    logic [LIST_W-1:0]       idx_reg, idx_next;
    logic                    oor_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0]        fill_reg [NUM_LISTS];
    logic [CNT_W-1:0]        rpos_reg [NUM_LISTS];
    kwm_cmp_ctl_t            ctl_reg, ctl_next;
    kwm_result_t             res_reg, res_next;
    logic                    result_valid_reg;
    kwm_result_t             result_reg;

    logic [CNT_W-1:0]  fill_sel;
    logic [CNT_W-1:0]  rpos_sel;
    logic              accept;
    logic              out_free;
    logic              load_ok;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [RAM_AW-1:0] ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;
    logic              fill_inc;
    logic              rpos_inc;
    logic              clear_all;
    kwm_cmp_stat_t     stat;

    assign fill_sel = fill_reg[idx_reg];
    assign rpos_sel = rpos_reg[idx_reg];
    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign load_ok  = !oor_reg && (fill_sel < CNT_W'(LIST_DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.operation == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (item.operation == OP_PULL)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LOAD:    state_next = ST_FINISH;
            ST_SCAN:
            begin
                if (idx_reg == LIST_W'(NUM_LISTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_PICK;
            ST_PICK:    state_next = ST_ADVANCE;
            ST_ADVANCE: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        item_stall = 1'b1;
        idx_next   = idx_reg;
        ctl_next   = '0;
        res_next   = res_reg;
        ram_we     = 1'b0;
        fill_inc   = 1'b0;
        rpos_inc   = 1'b0;
        clear_all  = 1'b0;
        ram_waddr  = kwm_addr(idx_reg, fill_sel);
        ram_raddr  = kwm_addr(idx_reg, rpos_sel);
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                res_next   = '0;
                if (item_valid)
                begin
                    if (item.operation == OP_PULL)
                    begin
                        idx_next     = '0;
                        ctl_next.clr = 1'b1;
                    end
                    else
                    begin
                        idx_next = LIST_W'(item.list_index);
                    end
                    clear_all = (item.operation == OP_CLEAR);
                end
            end
            ST_LOAD:
            begin
                ram_we            = load_ok;
                fill_inc          = load_ok;
                res_next.overflow = !load_ok;
            end
            ST_SCAN:
            begin
                // The head read here is compared next cycle, so the step info is registered.
                ctl_next.step     = 1'b1;
                ctl_next.idx      = idx_reg;
                ctl_next.nonempty = rpos_sel < fill_sel;
                ctl_next.count    = fill_sel - rpos_sel;
                if (idx_reg != LIST_W'(NUM_LISTS - 1))
                begin
                    idx_next = idx_reg + LIST_W'(1);
                end
            end
            ST_DRAIN:
            begin
            end
            ST_PICK:
            begin
                idx_next = stat.best_idx;
                if (stat.found)
                begin
                    res_next.merged_value = stat.best_val;
                    res_next.valid_res    = 1'b1;
                    res_next.last         = (stat.remaining == REM_W'(1));
                end
            end
            ST_ADVANCE:
            begin
                rpos_inc = stat.found;
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            ctl_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rpos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ctl_reg   <= ctl_next;
            if (clear_all)
            begin
                for (int i = 0; i < NUM_LISTS; i++)
                begin
                    fill_reg[i] <= '0;
                    rpos_reg[i] <= '0;
                end
            end
            if (fill_inc)
            begin
                fill_reg[idx_reg] <= fill_sel + CNT_W'(1);
            end
            if (rpos_inc)
            begin
                rpos_reg[idx_reg] <= rpos_sel + CNT_W'(1);
            end
            if (state_reg == ST_FINISH && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg    <= item.operation;
            oor_reg   <= int'(item.list_index) >= NUM_LISTS;
            value_reg <= item.value;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            result_reg <= res_reg;
        end
    end

    kwm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we && (op_reg == OP_LOAD)),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kwm_minsel u_minsel (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_reg),
        .head  ($signed(ram_rdata)),
        .stat  (stat)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sim/kwm_merge_checker.sv]
// Checker for the k-way merge: watches both channels, predicts every result and compares it.
module kwm_merge_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  kwm_pkg::kwm_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  kwm_pkg::kwm_result_t result,
    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    logic signed [VAL_W-1:0] list_words [NUM_LISTS][LIST_DEPTH];
    int unsigned             fill_level [NUM_LISTS];
    int unsigned             pull_level [NUM_LISTS];
    kwm_result_t             expected_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s is %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one accepted item to the predicted list state and returns its result.
    function automatic kwm_result_t merge_step(input kwm_item_t it);
        kwm_result_t r;
        bit          found;
        int          best;
        int          li;
        int unsigned left;
        r     = '0;
        found = 1'b0;
        best  = 0;
        left  = 0;
        li    = int'(it.list_index);
        case (it.operation)
            OP_LOAD:
            begin
                if (li >= NUM_LISTS || fill_level[li] >= LIST_DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    list_words[li][fill_level[li]] = it.value;
                    fill_level[li]++;
                end
            end
            OP_PULL:
            begin
                for (int k = 0; k < NUM_LISTS; k++)
                begin
                    if (pull_level[k] < fill_level[k])
                    begin
                        left += fill_level[k] - pull_level[k];
                        // Strict compare keeps ties on the lowest list index.
                        if (!found || list_words[k][pull_level[k]] < list_words[best][pull_level[best]])
                        begin
                            found = 1'b1;
                            best  = k;
                        end
                    end
                end
                if (found)
                begin
                    r.merged_value = list_words[best][pull_level[best]];
                    r.valid_res    = 1'b1;
                    r.last         = (left == 1);
                    pull_level[best]++;
                end
            end
            OP_CLEAR:
            begin
                for (int k = 0; k < NUM_LISTS; k++)
                begin
                    fill_level[k] = 0;
                    pull_level[k] = 0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        kwm_result_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            pending   <= 0;
            expected_results.delete();
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                fill_level[k] = 0;
                pull_level[k] = 0;
            end
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transfer with no item outstanding",
                                    32'(result), 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.merged_value !== want.merged_value)
                        report_mismatch("merged_value", result.merged_value, want.merged_value);
                    if (result.valid_res !== want.valid_res)
                        report_mismatch("valid_res", 32'(result.valid_res), 32'(want.valid_res));
                    if (result.last !== want.last)
                        report_mismatch("last", 32'(result.last), 32'(want.last));
                    if (result.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
                end
            end
            if (item_valid && !item_stall)
                expected_results = {expected_results, merge_step(item)};
            pending <= expected_results.size();
        end
    end

endmodule

[sim/k_way_merge_min_select_tb.sv]
// Testbench top for the k-way merge: drives item transfers, paces the result side and gives the verdict.
module k_way_merge_min_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 30;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    kwm_item_t   item;
    logic        result_valid;
    logic        result_stall;
    kwm_result_t result;

    int mismatches;
    int pending;
    int items_sent    = 0;
    int results_taken = 0;
    int idle_cycles   = 0;
    bit gaps_on       = 1'b1;
    bit stalls_on     = 1'b1;

    k_way_merge_min_select dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    kwm_merge_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Any cycle with a transfer on either side resets the count.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("[k_way_merge_min_select] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: a random hold-off before each transfer, and twice a long one while
    // the sender keeps offering items, so that the block backs up into its input.
    initial
    begin
        int hold;
        int next_long_hold;
        int long_holds;
        next_long_hold = 300;
        long_holds     = 0;
        result_stall <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_holds < 2 && results_taken >= next_long_hold && item_valid)
            begin
                hold = LONG_HOLD;
                long_holds++;
                next_long_hold += 500;
            end
            else if (stalls_on)
                hold = $urandom_range(0, 9);
            else
                hold = 0;
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            results_taken++;
        end
    end

    // Valid stays high after a transfer unless a gap or a sender pause follows.
    task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
                             input logic [31:0] val);
        kwm_item_t it;
        int        gap;
        it.operation  = op;
        it.list_index = idx;
        it.value      = val;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
    endtask

    // Sender pause: waits until every predicted result has been taken.
    task automatic wait_all_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Loads one list in ascending order; the top of the range saturates into duplicates.
    task automatic load_ascending(input logic [2:0] idx, input int count, input bit narrow);
        longint cur;
        longint step;
        cur = narrow ? longint'($urandom_range(0, 16)) - 8 : longint'($signed($urandom));
        for (int i = 0; i < count; i++)
        begin
            send_item(OP_LOAD, idx, cur[31:0]);
            if (narrow)
                step = $urandom_range(0, 2);
            else if ($urandom_range(0, 3) == 0)
                step = longint'($urandom);
            else
                step = $urandom_range(0, 1000);
            cur += step;
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
        end
    endtask

    task automatic run_merge_set();
        int lens [NUM_LISTS];
        int total;
        int early;
        int pulls;
        bit narrow;
        total  = 0;
        early  = 0;
        narrow = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < NUM_LISTS; k++)
        begin
            lens[k] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            total  += lens[k];
        end
        for (int k = 0; k < NUM_LISTS; k++)
        begin
            if (lens[k] > 0)
            begin
                load_ascending(3'(k), lens[k], narrow);
                // An occasional pull between loads leaves the merged output unsorted.
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(OP_PULL, 3'($urandom_range(0, 7)), $urandom);
                    early++;
                end
            end
        end
        pulls = total - early + $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0)
            pulls = $urandom_range(0, pulls);
        for (int i = 0; i < pulls; i++)
            send_item(OP_PULL, 3'($urandom_range(0, 7)), $urandom);
        if ($urandom_range(0, 3) != 0)
            send_item(OP_CLEAR, 3'($urandom_range(0, 7)), $urandom);
    endtask

    // Fills one list past its depth; pulled slots are not reused, so loads stay dropped.
    task automatic fill_one_list();
        logic [2:0] idx;
        idx = 3'($urandom_range(0, 7));
        send_item(OP_CLEAR, 3'd0, 32'd0);
        load_ascending(idx, LIST_DEPTH + 3, 1'b0);
        for (int i = 0; i < 5; i++)
            send_item(OP_PULL, idx, $urandom);
        load_ascending(idx, 2, 1'b1);
        send_item(OP_CLEAR, idx, $urandom);
    endtask

    task automatic run_noise();
        int count;
        count = $urandom_range(6, 12);
        for (int i = 0; i < count; i++)
            send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom);
    endtask

    initial
    begin
        int  kind;
        bit  fill_done;
        fill_done = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pulls, extremes, ties between and within lists, an unsorted
        // list and the undefined operation.
        send_item(OP_CLEAR, 3'd0, 32'd0);
        send_item(OP_PULL, 3'd0, 32'd0);
        send_item(OP_LOAD, 3'd0, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 3'(NUM_LISTS - 1), 32'h8000_0000);
        send_item(OP_LOAD, 3'd3, 32'd0);
        send_item(OP_LOAD, 3'd3, 32'd0);
        send_item(OP_LOAD, 3'd5, 32'd0);
        send_item(OP_LOAD, 3'd1, 32'hFFFF_FFFF);
        send_item(2'd3, 3'd7, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            send_item(OP_PULL, 3'd7, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 3'd2, 32'd5);
        send_item(OP_LOAD, 3'd2, -32'sd5);
        send_item(OP_PULL, 3'd0, 32'd0);
        send_item(OP_LOAD, 3'd4, 32'd1);
        send_item(OP_PULL, 3'd0, 32'd0);
        send_item(OP_PULL, 3'd0, 32'd0);
        send_item(OP_CLEAR, 3'd7, 32'hFFFF_FFFF);
        send_item(OP_PULL, 3'd0, 32'd0);
        wait_all_results();

        while (items_sent < ITEM_TARGET)
        begin
            if (!fill_done && items_sent > 400)
            begin
                fill_one_list();
                fill_done = 1'b1;
            end
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                run_merge_set();
            else if (kind < 9)
                run_noise();
            else
                send_item(OP_CLEAR, 3'($urandom_range(0, 7)), $urandom);
            if ($urandom_range(0, 5) == 0)
                wait_all_results();
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[k_way_merge_min_select] OK");
        else
            $display("[k_way_merge_min_select] ERROR");
        $finish;
    end

endmodule
